// ===== rtl/rol_pkg.sv =====
// rol_pkg: shared types and constants of the recursive owner lock bank
// no dependencies; used by the decision logic, the top level, the checker and the bench

package rol_pkg;

   localparam int DEF_NUM_LOCKS = 8;
   localparam int IDX_W = 3;
   localparam int CPU_W = 4;
   localparam int CNT_W = 32;

   localparam logic [CNT_W-1:0] CNT_CLAIM = 32'h0000_0101;
   localparam logic [CNT_W-1:0] CNT_BASE  = 32'h0000_0100;
   localparam logic [7:0]       DEPTH_MAX = 8'hff;
   localparam logic [CPU_W-1:0] CPU_NONE  = 4'd0;

   typedef enum logic {
      OP_ACQUIRE = 1'b0,
      OP_RELEASE = 1'b1
   } op_type;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_BLOCKED   = 3'd1,
      ST_NOT_OWNER = 3'd2,
      ST_MISMATCH  = 3'd3,
      ST_FLAG      = 3'd4,
      ST_OVERFLOW  = 3'd5,
      ST_DEPTH     = 3'd6
   } status_type;

   // outcome of one transaction: response fields and the state write
   typedef struct packed {
      status_type       status;
      logic             recursive;
      logic [CNT_W-1:0] counter;
      logic             hook;
      logic             wr_en;
      logic [CPU_W-1:0] new_owner;
      logic [CNT_W-1:0] new_count;
   } dec_type;

endpackage

// ===== rtl/rol_if.sv =====
// rol_req_if / rol_rsp_if: valid-ready channels of the lock bank
// request carries one lock operation, response carries its outcome

interface rol_req_if;
   logic        valid;
   logic        ready;
   logic        operation;
   logic [2:0]  lock_index;
   logic [3:0]  cpu_id;
   logic        token_recursive;
   logic [31:0] token_counter;

   modport source (output valid, operation, lock_index, cpu_id, token_recursive,
                   token_counter, input ready);
   modport sink (input valid, operation, lock_index, cpu_id, token_recursive,
                 token_counter, output ready);
endinterface

interface rol_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  status;
   logic        out_recursive;
   logic [31:0] out_counter;
   logic        run_unlock_hook;

   modport source (output valid, status, out_recursive, out_counter, run_unlock_hook,
                   input ready);
   modport sink (input valid, status, out_recursive, out_counter, run_unlock_hook,
                 output ready);
endinterface

// ===== rtl/recursive_owner_lock.sv =====
// recursive_owner_lock: bank of recursive owner locks with generation-counted tokens
// a request is registered in the request stage, its outcome in the response register
// throughput: one transaction per cycle unless the response stalls; the table is read
// in the request cycle, written as the result is registered, with bypass between them
// reset: synchronous; all locks read as free with counter 0x100 right after reset
// depends on rol_pkg, rol_if and rol_decide

module recursive_owner_lock
   import rol_pkg::*;
#(
   parameter int NUM_LOCKS = DEF_NUM_LOCKS
)(
   input logic         clock,
   input logic         reset,
   rol_req_if.sink     req,
   rol_rsp_if.source   rsp
);

   localparam int AW = (NUM_LOCKS > 1) ? $clog2(NUM_LOCKS) : 1;
   localparam logic [8:0] NUM_LOCKS_V = 9'(NUM_LOCKS);

   // lock table, no reset; per-entry valid bits stand in for the reset value
   logic [CPU_W-1:0] owner_mem [NUM_LOCKS];
   logic [CNT_W-1:0] count_mem [NUM_LOCKS];
   logic [NUM_LOCKS-1:0] lock_vld_ff;

   // request stage
   logic             s1_valid_ff;
   op_type           s1_op_ff;
   logic [IDX_W-1:0] s1_idx_ff;
   logic [CPU_W-1:0] s1_cpu_ff;
   logic             s1_flag_ff;
   logic [CNT_W-1:0] s1_tcnt_ff;
   logic             s1_vld_ff;
   logic [CPU_W-1:0] rd_owner_ff;
   logic [CNT_W-1:0] rd_count_ff;
   logic             s1_byp_ff;
   logic [CPU_W-1:0] s1_byp_owner_ff;
   logic [CNT_W-1:0] s1_byp_count_ff;

   // response register
   logic             rsp_valid_ff;
   status_type       rsp_status_ff;
   logic             rsp_rec_ff;
   logic [CNT_W-1:0] rsp_cnt_ff;
   logic             rsp_hook_ff;

   logic             out_free;
   logic             s1_adv;
   logic             req_fire;
   logic             wr_en;
   logic             byp_in;
   logic [AW-1:0]    req_addr;
   logic [AW-1:0]    s1_addr;
   logic             s1_in_range;
   logic [CPU_W-1:0] eff_owner;
   logic [CNT_W-1:0] eff_count;
   dec_type          dec;

   assign out_free  = !rsp_valid_ff || rsp.ready;
   assign s1_adv    = s1_valid_ff && out_free;
   assign req.ready = !s1_valid_ff || out_free;
   assign req_fire  = req.valid && req.ready;

   assign req_addr    = AW'(req.lock_index);
   assign s1_addr     = AW'(s1_idx_ff);
   assign s1_in_range = (9'(s1_idx_ff) < NUM_LOCKS_V);

   assign wr_en  = s1_adv && dec.wr_en;
   // the entry being written this edge is the one the new request reads
   assign byp_in = wr_en && (s1_idx_ff == req.lock_index);

   always_comb begin
      if (s1_byp_ff) begin
         eff_owner = s1_byp_owner_ff;
         eff_count = s1_byp_count_ff;
      end else if (s1_vld_ff) begin
         eff_owner = rd_owner_ff;
         eff_count = rd_count_ff;
      end else begin
         eff_owner = CPU_NONE;
         eff_count = CNT_BASE;
      end
   end

   rol_decide u_decide (
      .in_range        (s1_in_range),
      .op              (s1_op_ff),
      .cpu_id          (s1_cpu_ff),
      .token_recursive (s1_flag_ff),
      .token_counter   (s1_tcnt_ff),
      .cur_owner       (eff_owner),
      .cur_count       (eff_count),
      .dec             (dec)
   );

   always_ff @(posedge clock) begin
      if (wr_en) begin
         owner_mem[s1_addr] <= dec.new_owner;
         count_mem[s1_addr] <= dec.new_count;
      end
      if (req_fire) begin
         rd_owner_ff <= owner_mem[req_addr];
         rd_count_ff <= count_mem[req_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lock_vld_ff <= '0;
      end else if (wr_en) begin
         lock_vld_ff[s1_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_fire) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_adv) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_op_ff        <= op_type'(req.operation);
         s1_idx_ff       <= req.lock_index;
         s1_cpu_ff       <= req.cpu_id;
         s1_flag_ff      <= req.token_recursive;
         s1_tcnt_ff      <= req.token_counter;
         s1_vld_ff       <= lock_vld_ff[req_addr];
         s1_byp_ff       <= byp_in;
         s1_byp_owner_ff <= dec.new_owner;
         s1_byp_count_ff <= dec.new_count;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_adv) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         rsp_status_ff <= dec.status;
         rsp_rec_ff    <= dec.recursive;
         rsp_cnt_ff    <= dec.counter;
         rsp_hook_ff   <= dec.hook;
      end
   end

   assign rsp.valid           = rsp_valid_ff;
   assign rsp.status          = rsp_status_ff;
   assign rsp.out_recursive   = rsp_rec_ff;
   assign rsp.out_counter     = rsp_cnt_ff;
   assign rsp.run_unlock_hook = rsp_hook_ff;

endmodule

// ===== rtl/rol_decide.sv =====
// rol_decide: acquire/release decision for one lock entry
// combinational; depends on rol_pkg

module rol_decide
   import rol_pkg::*;
(
   input  logic             in_range,
   input  op_type           op,
   input  logic [CPU_W-1:0] cpu_id,
   input  logic             token_recursive,
   input  logic [CNT_W-1:0] token_counter,
   input  logic [CPU_W-1:0] cur_owner,
   input  logic [CNT_W-1:0] cur_count,
   output dec_type          dec
);

   logic [7:0]       depth;
   logic [CNT_W-1:0] tcnt_inc;
   logic             tok_nonzero;

   assign depth       = cur_count[7:0];
   assign tcnt_inc    = token_counter + CNT_W'(1);
   assign tok_nonzero = (token_counter[7:0] != 8'd0);

   always_comb begin
      dec           = '0;
      dec.status    = ST_OK;
      dec.new_owner = cur_owner;
      dec.new_count = cur_count;
      if (!in_range || cpu_id == CPU_NONE) begin
         dec.status = ST_NOT_OWNER;
      end else begin
         unique case (op)
            OP_ACQUIRE: begin
               priority if (cur_owner == cpu_id) begin
                  if (depth == DEPTH_MAX) begin
                     dec.status = ST_OVERFLOW;
                  end else if (depth == 8'd0) begin
                     dec.status = ST_DEPTH;
                  end else begin
                     // nested entry: bump depth, token carries old counter
                     dec.wr_en     = 1'b1;
                     dec.new_count = cur_count + CNT_W'(1);
                     dec.recursive = 1'b1;
                     dec.counter   = cur_count;
                  end
               end else if (cur_owner != CPU_NONE) begin
                  dec.status = ST_BLOCKED;
               end else if (depth != 8'd0) begin
                  dec.status = ST_DEPTH;
               end else begin
                  // fresh claim: next generation, depth one
                  dec.wr_en     = 1'b1;
                  dec.new_owner = cpu_id;
                  dec.new_count = cur_count + CNT_CLAIM;
                  dec.counter   = cur_count + CNT_BASE;
               end
            end
            OP_RELEASE: begin
               priority if (cur_owner != cpu_id) begin
                  dec.status = ST_NOT_OWNER;
               end else if (tcnt_inc != cur_count) begin
                  dec.status = ST_MISMATCH;
               end else if (tok_nonzero != token_recursive) begin
                  dec.status = ST_FLAG;
               end else begin
                  dec.wr_en     = 1'b1;
                  dec.new_count = token_counter;
                  if (!token_recursive) begin
                     dec.new_owner = CPU_NONE;
                     dec.hook      = 1'b1;
                  end
               end
            end
            default: dec.status = ST_NOT_OWNER;
         endcase
      end
   end

endmodule

// ===== rtl/rol_checker.sv =====
// rol_checker: port-level assertions for recursive_owner_lock
// depends on rol_pkg; attached to the top level by the bind below

module rol_checker
   import rol_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [2:0]  rsp_status,
   input logic        rsp_out_recursive,
   input logic [31:0] rsp_out_counter,
   input logic        rsp_run_unlock_hook
);

   // a stalled response transaction stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_out_counter))
      else $error("response dropped or changed while stalled");

   // hook only on a clean final release
   a_hook_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_run_unlock_hook |-> rsp_status == ST_OK
         && !rsp_out_recursive && rsp_out_counter == 32'd0)
      else $error("unlock hook with a token or a fault");

   // faults carry no token
   a_fault_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_OK |-> !rsp_out_recursive
         && rsp_out_counter == 32'd0 && !rsp_run_unlock_hook)
      else $error("fault response carries a token");

   // a fresh claim token always has a zero depth byte
   a_claim_depth: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_OK && !rsp_run_unlock_hook && !rsp_out_recursive
         && rsp_out_counter != 32'd0 |-> rsp_out_counter[7:0] == 8'd0)
      else $error("fresh acquire token with nonzero depth byte");

endmodule

bind recursive_owner_lock rol_checker u_rol_checker (
   .clock               (clock),
   .reset               (reset),
   .rsp_valid           (rsp.valid),
   .rsp_ready           (rsp.ready),
   .rsp_status          (rsp.status),
   .rsp_out_recursive   (rsp.out_recursive),
   .rsp_out_counter     (rsp.out_counter),
   .rsp_run_unlock_hook (rsp.run_unlock_hook)
);

// ===== verif/recursive_owner_lock_tb.sv =====
// recursive_owner_lock_tb: self-checking bench for the recursive owner lock bank
// tracks its own lock table to predict each response; random gaps on both sides
// depends on rol_pkg, rol_if (rol_req_if, rol_rsp_if) and recursive_owner_lock

module recursive_owner_lock_tb;
   import rol_pkg::*;

   localparam int NUM_LOCKS   = DEF_NUM_LOCKS;
   localparam int RANDOM_OPS  = 1320;
   localparam int MAX_HELD    = 256;
   localparam int HELD_CAP    = 12;
   localparam int HOLDOFF     = 80;
   localparam int SETTLE      = 12;
   localparam int CYCLE_LIMIT = 400000;

   typedef struct packed {
      status_type       status;
      logic             recursive;
      logic [CNT_W-1:0] counter;
      logic             hook;
   } lock_outcome_type;

   typedef struct packed {
      logic             recursive;
      logic [CNT_W-1:0] counter;
   } token_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   rol_req_if req ();
   rol_rsp_if rsp ();

   recursive_owner_lock #(.NUM_LOCKS(NUM_LOCKS)) dut (
      .clock (clock),
      .reset (reset),
      .req   (req),
      .rsp   (rsp)
   );

   // expected lock table
   logic [CPU_W-1:0] owner_table [NUM_LOCKS];
   logic [CNT_W-1:0] count_table [NUM_LOCKS];

   // tokens handed out and not yet given back, innermost last
   token_type held_tokens [NUM_LOCKS][MAX_HELD];
   int        held_count  [NUM_LOCKS];

   lock_outcome_type awaited_outcomes [$];
   int error_count = 0;
   int cycle_count = 0;
   bit req_gaps    = 1'b0;
   bit rsp_stalls  = 1'b0;
   int rsp_holdoff = 0;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic lock_outcome_type lock_outcome(op_type op, logic [IDX_W-1:0] idx,
         logic [CPU_W-1:0] cpu, logic flag, logic [CNT_W-1:0] tcnt);
      lock_outcome_type r;
      logic [CNT_W-1:0] cur;
      logic [7:0]       depth;
      r = '0;
      r.status = ST_NOT_OWNER;
      if (cpu == CPU_NONE || int'(idx) >= NUM_LOCKS) return r;
      cur = count_table[idx];
      depth = cur[7:0];
      if (op == OP_ACQUIRE) begin
         if (owner_table[idx] == cpu) begin
            if (depth == DEPTH_MAX) r.status = ST_OVERFLOW;
            else if (depth == 8'd0) r.status = ST_DEPTH;
            else begin
               count_table[idx] = cur + 32'd1;
               r.status = ST_OK;
               r.recursive = 1'b1;
               r.counter = cur;
            end
         end else if (owner_table[idx] != CPU_NONE) r.status = ST_BLOCKED;
         else if (depth != 8'd0) r.status = ST_DEPTH;
         else begin
            owner_table[idx] = cpu;
            count_table[idx] = cur + CNT_CLAIM;
            r.status = ST_OK;
            r.counter = cur + CNT_BASE;
         end
      end else if (owner_table[idx] != cpu) r.status = ST_NOT_OWNER;
      else if (tcnt + 32'd1 != cur) r.status = ST_MISMATCH;
      else if ((tcnt[7:0] != 8'd0) != flag) r.status = ST_FLAG;
      else begin
         r.status = ST_OK;
         count_table[idx] = tcnt;
         // an outer token frees the lock
         if (!flag) begin
            owner_table[idx] = CPU_NONE;
            r.hook = 1'b1;
         end
      end
      return r;
   endfunction

   function automatic token_type top_token(logic [IDX_W-1:0] idx);
      if (held_count[idx] == 0) return '0;
      return held_tokens[idx][held_count[idx] - 1];
   endfunction

   function automatic logic [CPU_W-1:0] random_cpu();
      if ($urandom_range(0, 31) == 0) return CPU_NONE;
      return CPU_W'($urandom_range(1, 15));
   endfunction

   task automatic send_lock_op(op_type op, logic [IDX_W-1:0] idx, logic [CPU_W-1:0] cpu,
         logic flag, logic [CNT_W-1:0] tcnt);
      int gap;
      lock_outcome_type r;
      gap = req_gaps ? $urandom_range(0, 12) : 0;
      if (gap > 0) begin
         req.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req.valid           <= 1'b1;
      req.operation       <= op;
      req.lock_index      <= idx;
      req.cpu_id          <= cpu;
      req.token_recursive <= flag;
      req.token_counter   <= tcnt;
      @(posedge clock);
      while (req.ready !== 1'b1) @(posedge clock);
      r = lock_outcome(op, idx, cpu, flag, tcnt);
      awaited_outcomes.push_back(r);
      if (r.status == ST_OK) begin
         if (op == OP_ACQUIRE) begin
            held_tokens[idx][held_count[idx]] = {r.recursive, r.counter};
            held_count[idx]++;
         end else begin
            held_count[idx]--;
         end
      end
      @(negedge clock);
   endtask

   task automatic release_top(logic [IDX_W-1:0] idx, logic [CPU_W-1:0] cpu);
      token_type t;
      t = top_token(idx);
      send_lock_op(OP_RELEASE, idx, cpu, t.recursive, t.counter);
   endtask

   task automatic wait_drained();
      req.valid <= 1'b0;
      while (awaited_outcomes.size() != 0) @(negedge clock);
   endtask

   task automatic random_lock_op();
      logic [IDX_W-1:0] idx;
      logic [CPU_W-1:0] owner;
      logic [CPU_W-1:0] cpu;
      token_type        t;
      int               pick;
      idx = IDX_W'($urandom_range(0, NUM_LOCKS - 1));
      owner = owner_table[idx];
      t = top_token(idx);
      pick = $urandom_range(0, 99);
      if (pick < 45 && held_count[idx] >= HELD_CAP) pick = 60;
      if (pick >= 45 && pick < 85 && owner == CPU_NONE) pick = 0;
      if (pick < 45) begin
         cpu = (owner != CPU_NONE && $urandom_range(0, 3) != 0) ? owner : random_cpu();
         send_lock_op(OP_ACQUIRE, idx, cpu, 1'b0, CNT_W'($urandom()));
      end else if (pick < 85) begin
         release_top(idx, owner);
      end else begin
         cpu = (owner != CPU_NONE && $urandom_range(0, 1) != 0) ? owner : random_cpu();
         case ($urandom_range(0, 3))
            0: begin
               t.recursive = 1'($urandom_range(0, 1));
               t.counter = CNT_W'($urandom());
            end
            1: t.counter = ($urandom_range(0, 1) != 0) ? t.counter + 32'd1 : t.counter - 32'd1;
            2: t.recursive = !t.recursive;
            default: begin
               // an outer token handed back too early
               if (held_count[idx] > 1)
                  t = held_tokens[idx][$urandom_range(0, held_count[idx] - 2)];
               else
                  t.counter = CNT_W'($urandom());
            end
         endcase
         send_lock_op(OP_RELEASE, idx, cpu, t.recursive, t.counter);
      end
   endtask

   task automatic test_lock_bank();
      req_gaps = 1'b0;
      rsp_stalls = 1'b0;
      for (int i = 0; i < NUM_LOCKS; i++)
         send_lock_op(OP_ACQUIRE, IDX_W'(i), CPU_W'(i + 1), 1'b0, '0);
      for (int i = 0; i < NUM_LOCKS; i++)
         release_top(IDX_W'(i), CPU_W'(i + 1));
   endtask

   task automatic test_ownership_faults();
      token_type t;
      req_gaps = 1'b1;
      rsp_stalls = 1'b1;
      send_lock_op(OP_ACQUIRE, 3'd0, 4'd3, 1'b0, '0);
      send_lock_op(OP_ACQUIRE, 3'd0, 4'd5, 1'b0, '1);
      release_top(3'd0, 4'd5);
      send_lock_op(OP_ACQUIRE, 3'd0, 4'd3, 1'b0, '0);
      t = top_token(3'd0);
      send_lock_op(OP_RELEASE, 3'd0, 4'd3, 1'b1, t.counter + 32'd1);
      send_lock_op(OP_RELEASE, 3'd0, 4'd3, 1'b0, t.counter);
      release_top(3'd0, 4'd3);
      t = top_token(3'd0);
      send_lock_op(OP_RELEASE, 3'd0, 4'd3, 1'b1, t.counter);
      send_lock_op(OP_RELEASE, 3'd0, 4'd3, 1'b1, '1);
      release_top(3'd0, 4'd3);
      // stale token on a free lock
      send_lock_op(OP_RELEASE, 3'd0, 4'd3, 1'b0, t.counter);
      send_lock_op(OP_ACQUIRE, 3'd0, CPU_NONE, 1'b1, '1);
      send_lock_op(OP_RELEASE, 3'd1, CPU_NONE, 1'b0, '0);
      send_lock_op(OP_ACQUIRE, 3'd7, 4'd15, 1'b0, '0);
      send_lock_op(OP_ACQUIRE, 3'd7, 4'd15, 1'b0, '0);
      send_lock_op(OP_RELEASE, 3'd7, 4'd15, 1'b0, '0);
      release_top(3'd7, 4'd15);
      release_top(3'd7, 4'd15);
   endtask

   task automatic test_depth_overflow();
      req_gaps = 1'b0;
      rsp_stalls = 1'b1;
      send_lock_op(OP_ACQUIRE, 3'd2, 4'd9, 1'b0, '0);
      // the last of these finds the depth byte full
      repeat (int'(DEPTH_MAX)) send_lock_op(OP_ACQUIRE, 3'd2, 4'd9, 1'b0, '0);
      while (held_count[2] > 0) release_top(3'd2, 4'd9);
   endtask

   task automatic test_backpressure();
      wait_drained();
      req_gaps = 1'b0;
      rsp_stalls = 1'b0;
      rsp_holdoff = HOLDOFF;
      repeat (40) random_lock_op();
      wait_drained();
   endtask

   task automatic test_random_traffic();
      for (int phase = 0; phase < 4; phase++) begin
         req_gaps = (phase % 2) == 1;
         rsp_stalls = phase >= 2;
         repeat (RANDOM_OPS / 4) random_lock_op();
      end
   endtask

   always @(posedge clock) begin : check_responses
      lock_outcome_type e;
      if (!reset && rsp.valid === 1'b1 && rsp.ready === 1'b1) begin
         if (awaited_outcomes.size() == 0) begin
            $error("unexpected response transaction, status %0d", rsp.status);
            error_count++;
         end else begin
            e = awaited_outcomes.pop_front();
            if (rsp.status !== e.status) begin
               $error("status: expected %0d, got %0d", e.status, rsp.status);
               error_count++;
            end
            if (rsp.out_recursive !== e.recursive) begin
               $error("out_recursive: expected %0d, got %0d", e.recursive, rsp.out_recursive);
               error_count++;
            end
            if (rsp.out_counter !== e.counter) begin
               $error("out_counter: expected %h, got %h", e.counter, rsp.out_counter);
               error_count++;
            end
            if (rsp.run_unlock_hook !== e.hook) begin
               $error("run_unlock_hook: expected %0d, got %0d", e.hook, rsp.run_unlock_hook);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   initial begin : drive_rsp_ready
      int gap;
      rsp.ready = 1'b0;
      wait (!reset);
      @(negedge clock);
      forever begin
         gap = rsp_stalls ? $urandom_range(0, 12) : 0;
         if (rsp_holdoff > 0) begin
            gap = rsp_holdoff;
            rsp_holdoff = 0;
         end
         if (gap > 0) begin
            rsp.ready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp.ready <= 1'b1;
         @(posedge clock);
         while (rsp.valid !== 1'b1 && rsp_holdoff == 0) @(posedge clock);
         @(negedge clock);
      end
   end

   initial begin
      req.valid           = 1'b0;
      req.operation       = OP_ACQUIRE;
      req.lock_index      = '0;
      req.cpu_id          = CPU_NONE;
      req.token_recursive = 1'b0;
      req.token_counter   = '0;
      for (int i = 0; i < NUM_LOCKS; i++) begin
         owner_table[i] = CPU_NONE;
         count_table[i] = CNT_BASE;
         held_count[i] = 0;
      end
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_lock_bank();
      test_ownership_faults();
      test_depth_overflow();
      test_backpressure();
      test_random_traffic();
      wait_drained();
      repeat (SETTLE) @(negedge clock);
      if (error_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
